// ----- rtl/tbna_pkg.sv -----
// Shared types and constants of the tree bitmap number allocator.
package tbna_pkg;

  // Default tree depth: NODES = 2**TREE_LEVELS node slots
  localparam int TREE_LEVELS_DEF = 10;

  // Fixed field widths of the request and result channels
  localparam int OP_W  = 2;
  localparam int NUM_W = 10;

  // Request opcodes
  typedef enum logic [OP_W-1:0] {
    OP_QUERY = 2'd0,
    OP_SET   = 2'd1,
    OP_FIND  = 2'd2
  } op_t;

  // Status returned by the node evaluation unit
  typedef struct packed {
    logic blk_a;
    logic blk_b;
  } blk_t;

endpackage

// ----- rtl/tbna_bitmem.sv -----
// One-bit-wide memory with one write port and two registered read ports.
module tbna_bitmem #(
  parameter int AW = tbna_pkg::TREE_LEVELS_DEF
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic          wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic          rdata_a,
  output logic          rdata_b
);
  import tbna_pkg::*;

  localparam int DEPTH = 1 << AW;

  logic mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read ports
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- rtl/tbna_node_eval.sv -----
// Shared evaluation unit: blocked status of two nodes with out-of-tree overrides.
module tbna_node_eval #(
  parameter int IW = tbna_pkg::TREE_LEVELS_DEF
) (
  input  logic          [IW:0] idx_a,
  input  logic          [IW:0] idx_b,
  input  logic                 taken_a,
  input  logic                 full_a,
  input  logic                 taken_b,
  input  logic                 full_b,
  output tbna_pkg::blk_t       blk
);
  import tbna_pkg::*;

  logic tov_a, fov_a, tov_b, fov_b;

  // Index at or above NODES reads taken; at or above NODES/2 reads full
  always_comb begin
    tov_a = idx_a[IW];
    fov_a = idx_a[IW] | idx_a[IW-1];
    tov_b = idx_b[IW];
    fov_b = idx_b[IW] | idx_b[IW-1];
    blk.blk_a = (tov_a | taken_a) & (fov_a | full_a);
    blk.blk_b = (tov_b | taken_b) & (fov_b | full_b);
  end

endmodule

// ----- rtl/tree_bitmap_number_allocator.sv -----
// Top level of the tree bitmap number allocator: sequencer, bit memories, node evaluation.
//
// Numbers are nodes 1..NODES-1 of an implicit binary tree, NODES = 2**TREE_LEVELS.
// Request channel (in_valid/in_stall): in_op selects query (0), set or clear (1)
// or find free number (2); in_number addresses query and set; in_used_flag
// gives the new taken bit for set. A request is taken when in_valid is high
// and in_stall low. Every request, op 3 included, returns one result on the
// out_valid/out_stall channel: out_taken for query, out_free_number or
// out_none_free for find, all zero otherwise.
// One request at a time; in_stall is high until it is done, so requests are
// accepted one after another. Out-of-tree and unused ops go straight to the
// result; a query reads the node once, a set writes the taken bit and then
// walks toward the root one level per step, and a find descends one level
// per step from the root. Each step reads the taken and full bit memories,
// each with two registered read ports, and then evaluates the result.
// After reset a clearing pass writes zero to all NODES entries of both
// memories, one entry a cycle; requests are stalled meanwhile.
// The result sits in an output register; while the receiver stalls it holds,
// and the next request is accepted but its result waits for the register.
module tree_bitmap_number_allocator #(
  parameter int TREE_LEVELS = tbna_pkg::TREE_LEVELS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [tbna_pkg::OP_W-1:0]  in_op,
  input  logic [tbna_pkg::NUM_W-1:0] in_number,
  input  logic                       in_used_flag,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_taken,
  output logic [tbna_pkg::NUM_W-1:0] out_free_number,
  output logic                       out_none_free
);
  import tbna_pkg::*;

  localparam int IW = TREE_LEVELS;

  typedef enum logic [8:0] {
    ST_CLEAR   = 9'b000000001,
    ST_IDLE    = 9'b000000010,
    ST_LOOK    = 9'b000000100,
    ST_LOOK_EV = 9'b000001000,
    ST_WALK_RD = 9'b000010000,
    ST_WALK_EV = 9'b000100000,
    ST_FIND_RD = 9'b001000000,
    ST_FIND_EV = 9'b010000000,
    ST_RESP    = 9'b100000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [IW-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic [IW-1:0]     node_r, node_nxt;
  logic [OP_W-1:0]   op_r, op_nxt;
  logic              used_r, used_nxt;
  logic              full_n_r, full_n_nxt;
  logic              res_taken_r, res_taken_nxt;
  logic [NUM_W-1:0]  res_free_r, res_free_nxt;
  logic              res_none_r, res_none_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_taken_r, out_taken_nxt;
  logic [NUM_W-1:0]  out_free_r, out_free_nxt;
  logic              out_none_r, out_none_nxt;

  // Memory ports
  logic              t_we, t_wdata, f_we, f_wdata;
  logic [IW-1:0]     t_waddr, f_waddr;
  logic [IW-1:0]     t_ra, t_rb, f_ra, f_rb;
  logic              t_da, t_db, f_da, f_db;

  // Evaluation unit ports
  logic [IW:0]       ev_idx_a, ev_idx_b;
  logic              ev_full_a, ev_full_b;
  blk_t              ev_blk;

  // Tree neighbors of the current node
  logic [IW:0]       lc, rc;
  logic [IW-1:0]     sib, par, child;
  logic              child_taken;
  logic              status, in_tree;
  logic [IW-1:0]     in_idx;
  logic              is_walk;
  logic              out_free_slot;

  tbna_bitmem #(.AW(IW)) u_taken_mem (
    .clk     (clk),
    .we      (t_we),
    .waddr   (t_waddr),
    .wdata   (t_wdata),
    .raddr_a (t_ra),
    .raddr_b (t_rb),
    .rdata_a (t_da),
    .rdata_b (t_db)
  );

  tbna_bitmem #(.AW(IW)) u_full_mem (
    .clk     (clk),
    .we      (f_we),
    .waddr   (f_waddr),
    .wdata   (f_wdata),
    .raddr_a (f_ra),
    .raddr_b (f_rb),
    .rdata_a (f_da),
    .rdata_b (f_db)
  );

  tbna_node_eval #(.IW(IW)) u_eval (
    .idx_a   (ev_idx_a),
    .idx_b   (ev_idx_b),
    .taken_a (t_da),
    .full_a  (ev_full_a),
    .taken_b (t_db),
    .full_b  (ev_full_b),
    .blk     (ev_blk)
  );

  // Neighbor indices and request decode
  always_comb begin
    lc      = {node_r, 1'b0};
    rc      = {node_r, 1'b1};
    sib     = node_r ^ IW'(1);
    par     = node_r >> 1;
    in_tree = (in_number >> TREE_LEVELS) == '0;
    in_idx  = IW'(in_number);
    is_walk = (state_r == ST_WALK_EV);
  end

  // Route the walk or the descent into the shared evaluation unit
  always_comb begin
    if (is_walk) begin
      ev_idx_a  = {1'b0, node_r};
      ev_idx_b  = {1'b0, sib};
      ev_full_a = full_n_r;
      ev_full_b = f_da;
    end else begin
      ev_idx_a  = lc;
      ev_idx_b  = rc;
      ev_full_a = f_da;
      ev_full_b = f_db;
    end
    status      = ev_blk.blk_a & ev_blk.blk_b;
    child       = ev_blk.blk_a ? rc[IW-1:0] : lc[IW-1:0];
    child_taken = ev_blk.blk_a ? t_db : t_da;
  end

  // Read addresses for the current step
  always_comb begin
    t_ra = node_r;
    t_rb = sib;
    f_ra = node_r;
    f_rb = par;
    case (state_r)
      ST_WALK_RD: begin
        f_ra = sib;
      end
      ST_FIND_RD: begin
        t_ra = lc[IW-1:0];
        t_rb = rc[IW-1:0];
        f_ra = lc[IW-1:0];
        f_rb = rc[IW-1:0];
      end
      default: begin
      end
    endcase
  end

  assign out_free_slot = !out_valid_r || !out_stall;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    node_nxt      = node_r;
    op_nxt        = op_r;
    used_nxt      = used_r;
    full_n_nxt    = full_n_r;
    res_taken_nxt = res_taken_r;
    res_free_nxt  = res_free_r;
    res_none_nxt  = res_none_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_taken_nxt = out_taken_r;
    out_free_nxt  = out_free_r;
    out_none_nxt  = out_none_r;
    t_we          = 1'b0;
    t_waddr       = node_r;
    t_wdata       = used_r;
    f_we          = 1'b0;
    f_waddr       = par;
    f_wdata       = status;

    case (state_r)
      // Sweep zero through both memories
      ST_CLEAR: begin
        t_we        = 1'b1;
        t_waddr     = clr_cnt_r;
        t_wdata     = 1'b0;
        f_we        = 1'b1;
        f_waddr     = clr_cnt_r;
        f_wdata     = 1'b0;
        clr_cnt_nxt = clr_cnt_r + IW'(1);
        if (clr_cnt_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end

      // Take a request and decode it
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt        = in_op;
          used_nxt      = in_used_flag;
          node_nxt      = in_idx;
          res_taken_nxt = 1'b0;
          res_free_nxt  = '0;
          res_none_nxt  = 1'b0;
          case (op_t'(in_op))
            OP_QUERY: begin
              if (in_tree) begin
                state_nxt = ST_LOOK;
              end else begin
                res_taken_nxt = 1'b1;
                state_nxt     = ST_RESP;
              end
            end
            OP_SET: begin
              state_nxt = in_tree ? ST_LOOK : ST_RESP;
            end
            OP_FIND: begin
              node_nxt  = IW'(1);
              state_nxt = ST_LOOK;
            end
            default: begin
              state_nxt = ST_RESP;
            end
          endcase
        end
      end

      // Read taken and full bits of the addressed node
      ST_LOOK: begin
        state_nxt = ST_LOOK_EV;
      end

      ST_LOOK_EV: begin
        if (op_r == OP_QUERY) begin
          res_taken_nxt = t_da;
          state_nxt     = ST_RESP;
        end else if (op_r == OP_SET) begin
          // Write the new taken bit, then walk up unless nothing changed
          if (t_da == used_r) begin
            state_nxt = ST_RESP;
          end else begin
            t_we       = 1'b1;
            full_n_nxt = f_da;
            state_nxt  = (node_r == '0) ? ST_RESP : ST_WALK_RD;
          end
        end else begin
          // Root free: done, else descend
          if (!t_da) begin
            res_free_nxt = NUM_W'(node_r);
            state_nxt    = ST_RESP;
          end else begin
            state_nxt = ST_FIND_RD;
          end
        end
      end

      ST_WALK_RD: begin
        state_nxt = ST_WALK_EV;
      end

      // Recompute the parent's full bit; stop when it holds
      ST_WALK_EV: begin
        if (f_db == status) begin
          state_nxt = ST_RESP;
        end else begin
          f_we       = 1'b1;
          node_nxt   = par;
          full_n_nxt = status;
          state_nxt  = (par == '0) ? ST_RESP : ST_WALK_RD;
        end
      end

      ST_FIND_RD: begin
        state_nxt = ST_FIND_EV;
      end

      // Descend into the first child that is not taken and full
      ST_FIND_EV: begin
        if (status) begin
          res_none_nxt = 1'b1;
          state_nxt    = ST_RESP;
        end else if (!child_taken) begin
          res_free_nxt = NUM_W'(child);
          state_nxt    = ST_RESP;
        end else begin
          node_nxt  = child;
          state_nxt = ST_FIND_RD;
        end
      end

      // Hold the result until the output register is free
      ST_RESP: begin
        if (out_free_slot) begin
          out_valid_nxt = 1'b1;
          out_taken_nxt = res_taken_r;
          out_free_nxt  = res_free_r;
          out_none_nxt  = res_none_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    node_r      <= node_nxt;
    op_r        <= op_nxt;
    used_r      <= used_nxt;
    full_n_r    <= full_n_nxt;
    res_taken_r <= res_taken_nxt;
    res_free_r  <= res_free_nxt;
    res_none_r  <= res_none_nxt;
    out_taken_r <= out_taken_nxt;
    out_free_r  <= out_free_nxt;
    out_none_r  <= out_none_nxt;
  end

  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_taken       = out_taken_r;
  assign out_free_number = out_free_r;
  assign out_none_free   = out_none_r;

endmodule
